// ===== hdl/adsr_pkg.sv =====
// ----------------------------------------------------------------------------
// adsr_pkg
// Types and constants shared by the polyphonic ADSR envelope and its checker.
// ----------------------------------------------------------------------------
package adsr_pkg;

  localparam int NumNotes   = 128;
  localparam int NoteW      = $clog2(NumNotes);
  localparam int MaxAttack  = 255;
  localparam int MaxDecay   = 255;
  localparam int MaxRelease = 255;
  localparam int PosW       = 10;
  localparam int RposW      = 9;
  localparam int MultW      = 17;
  localparam int FracW      = 16;

  localparam logic [PosW-1:0] PosCap = PosW'(MaxAttack + MaxDecay + MaxRelease + 2);
  localparam logic [MultW-1:0] OneQ16 = MultW'(65536);

  typedef enum logic [2:0] {
    ActTick    = 3'd0,
    ActPress   = 3'd1,
    ActRelease = 3'd2,
    ActQHeld   = 3'd3,
    ActQRel    = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    PhOff     = 3'd0,
    PhAttack  = 3'd1,
    PhDecay   = 3'd2,
    PhSustain = 3'd3,
    PhRelease = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    RegAttack  = 3'd0,
    RegDecay   = 3'd1,
    RegSustain = 3'd2,
    RegRelease = 3'd3,
    RegPeriod  = 3'd4
  } reg_e;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StPrep,
    StDiv,
    StFin
  } state_e;

  typedef struct packed {
    logic [2:0]       action;
    logic [NoteW-1:0] note;
  } in_t;

  typedef struct packed {
    logic [MultW-1:0] multiplier;
    logic [2:0]       phase;
    logic             release_done;
  } out_t;

  typedef struct packed {
    logic [2:0]      mode;
    logic [PosW-1:0]  pos;
    logic [RposW-1:0] rpos;
  } entry_t;

endpackage

// ===== hdl/polyphonic_adsr_envelope.sv =====
// ----------------------------------------------------------------------------
// polyphonic_adsr_envelope
// Per-note ADSR envelope with a shared bit-serial divider for the level.
// ----------------------------------------------------------------------------
//   channel   | signals                          | direction
//   command   | start_i, busy_o, in_i            | in/out
//   result    | res_valid_o, res_o               | out
//   config    | psel..pwdata, prdata, pready     | in/out
//
// a command passes through the read, prep, divide and finish states; when a level
// is divided the divider retires one quotient bit per cycle in the divide state
// reset sets the configuration registers to their defaults and clears the
// prescaler and a valid bit per note; no clearing pass is needed
// the result strobe is high for one cycle; the receiver cannot stall it
module polyphonic_adsr_envelope (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  adsr_pkg::in_t       in_i,
  output logic                res_valid_o,
  output adsr_pkg::out_t      res_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int FW = adsr_pkg::FracW;

  // configuration
  logic [7:0]  attack_q, decay_q, sustain_q, release_q;
  logic [15:0] period_q;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= 8'd1;
      decay_q   <= 8'd1;
      sustain_q <= 8'd255;
      release_q <= 8'd1;
      period_q  <= 16'd1;
    end else if (cfg_wr) begin
      case (cfg_idx)
        adsr_pkg::RegAttack:  attack_q  <= (pwdata[7:0] == 8'd0) ? 8'd1 : pwdata[7:0];
        adsr_pkg::RegDecay:   decay_q   <= (pwdata[7:0] == 8'd0) ? 8'd1 : pwdata[7:0];
        adsr_pkg::RegSustain: sustain_q <= pwdata[7:0];
        adsr_pkg::RegRelease: release_q <= (pwdata[7:0] == 8'd0) ? 8'd1 : pwdata[7:0];
        adsr_pkg::RegPeriod:  period_q  <= (pwdata[15:0] == 16'd0) ? 16'd1 : pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      adsr_pkg::RegAttack:  prdata = {24'd0, attack_q};
      adsr_pkg::RegDecay:   prdata = {24'd0, decay_q};
      adsr_pkg::RegSustain: prdata = {24'd0, sustain_q};
      adsr_pkg::RegRelease: prdata = {24'd0, release_q};
      adsr_pkg::RegPeriod:  prdata = {16'd0, period_q};
      default:              prdata = 32'd0;
    endcase
  end

  // control
  adsr_pkg::state_e state_q, state_d;
  logic [3:0]  cnt_q;
  logic        div_need_q;
  logic        accept;

  assign accept = start_i & ~busy_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      adsr_pkg::StIdle: if (start_i) state_d = adsr_pkg::StRead;
      adsr_pkg::StRead: state_d = adsr_pkg::StPrep;
      adsr_pkg::StPrep: state_d = adsr_pkg::StDiv;
      adsr_pkg::StDiv: begin
        if (!div_need_q || cnt_q == 4'd15) state_d = adsr_pkg::StFin;
      end
      adsr_pkg::StFin: state_d = adsr_pkg::StIdle;
      default: state_d = adsr_pkg::StIdle;
    endcase
  end

  always_comb begin
    busy_o = (state_q != adsr_pkg::StIdle);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= adsr_pkg::StIdle;
    else         state_q <= state_d;
  end

  // note store
  adsr_pkg::entry_t            mem_q [adsr_pkg::NumNotes];
  adsr_pkg::entry_t            rd_q;
  logic [adsr_pkg::NumNotes-1:0] valid_q;
  logic                        rd_vld_q;
  adsr_pkg::in_t               cmd_q;
  adsr_pkg::entry_t            ent_new_q;
  logic                        we_q;

  always_ff @(posedge clk_i) begin
    if (accept) cmd_q <= in_i;
    if (state_q == adsr_pkg::StRead) rd_q <= mem_q[cmd_q.note];
    if (state_q == adsr_pkg::StFin && we_q) mem_q[cmd_q.note] <= ent_new_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (state_q == adsr_pkg::StRead) rd_vld_q <= valid_q[cmd_q.note];
      if (state_q == adsr_pkg::StFin && we_q) valid_q[cmd_q.note] <= 1'b1;
    end
  end

  // prescaler
  logic [15:0] tick_q;
  logic        armed_q;
  logic [16:0] tick_inc;

  assign tick_inc = {1'b0, tick_q} + 17'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= '0;
      armed_q <= 1'b0;
    end else if (state_q == adsr_pkg::StPrep && cmd_q.action == adsr_pkg::ActTick) begin
      if (tick_inc >= {1'b0, period_q}) begin
        tick_q  <= '0;
        armed_q <= 1'b1;
      end else begin
        tick_q  <= tick_inc[15:0];
        armed_q <= 1'b0;
      end
    end
  end

  // decode of the command against the note's entry
  adsr_pkg::entry_t ent, ent_new;
  logic        we, need, done;
  logic [2:0]  phase;
  logic [15:0] num, den;
  logic [8:0]  ad_sum;
  logic [7:0]  k;
  logic [15:0] d255, sk;
  logic [10:0] p_inc;
  logic [9:0]  p_new;
  logic [8:0]  r_inc;

  always_comb begin
    ent     = rd_vld_q ? rd_q : '0;
    ent_new = ent;
    we      = 1'b0;
    need    = 1'b0;
    done    = 1'b0;
    phase   = ent.mode;
    num     = '0;
    den     = 16'd1;
    ad_sum  = {1'b0, attack_q} + {1'b0, decay_q};
    k       = 8'(ent.pos - {2'b0, attack_q});
    d255    = {decay_q, 8'd0} - {8'd0, decay_q};
    sk      = (8'd255 - sustain_q) * k;
    p_inc   = {1'b0, ent.pos} + {10'd0, armed_q};
    p_new   = (p_inc > {1'b0, adsr_pkg::PosCap}) ? adsr_pkg::PosCap : p_inc[9:0];
    r_inc   = ent.rpos + {8'd0, armed_q};
    case (cmd_q.action)
      adsr_pkg::ActPress: begin
        we           = 1'b1;
        ent_new.pos  = '0;
        ent_new.mode = adsr_pkg::PhAttack;
      end
      adsr_pkg::ActRelease: begin
        if (ent.mode != adsr_pkg::PhOff) begin
          we           = 1'b1;
          ent_new.mode = adsr_pkg::PhRelease;
          ent_new.rpos = '0;
          ent_new.pos  = '0;
        end
      end
      adsr_pkg::ActQHeld: begin
        if (ent.mode == adsr_pkg::PhAttack || ent.mode == adsr_pkg::PhDecay ||
            ent.mode == adsr_pkg::PhSustain) begin
          need = 1'b1;
          if (ent.pos <= {2'b0, attack_q}) begin
            num = {6'd0, ent.pos};
            den = {8'd0, attack_q};
          end else if (ent.pos <= {1'b0, ad_sum}) begin
            num = d255 - sk;
            den = d255;
          end else begin
            num = {8'd0, sustain_q};
            den = 16'd255;
          end
          if (ent.mode != adsr_pkg::PhSustain) begin
            we          = 1'b1;
            ent_new.pos = p_new;
            if (p_new > {1'b0, ad_sum})               ent_new.mode = adsr_pkg::PhSustain;
            else if (p_new > {2'b0, attack_q})        ent_new.mode = adsr_pkg::PhDecay;
          end
        end
      end
      adsr_pkg::ActQRel: begin
        if (ent.mode == adsr_pkg::PhRelease) begin
          we = 1'b1;
          if (ent.rpos < {1'b0, release_q}) begin
            need = 1'b1;
            num  = {8'd0, release_q} - {7'd0, ent.rpos};
            den  = {8'd0, release_q};
          end
          ent_new.rpos = r_inc;
          if (r_inc >= {1'b0, release_q}) begin
            ent_new.rpos = '0;
            ent_new.mode = adsr_pkg::PhOff;
            done         = 1'b1;
          end
        end
      end
      default: phase = adsr_pkg::PhOff;
    endcase
  end

  // bit-serial divider: (num * 2^16 + den/2) / den with num <= den
  logic [15:0] rem_q, den_q, half_q;
  logic [16:0] quo_q, trial;
  logic [2:0]  phase_q;
  logic        done_q;

  assign trial = {rem_q, half_q[FW-1]};

  always_ff @(posedge clk_i) begin
    if (state_q == adsr_pkg::StPrep) begin
      den_q     <= den;
      half_q    <= den >> 1;
      ent_new_q <= ent_new;
      phase_q   <= phase;
      done_q    <= done;
      if (num >= den) begin
        rem_q <= '0;
        quo_q <= 17'd1;
      end else begin
        rem_q <= num;
        quo_q <= '0;
      end
    end else if (state_q == adsr_pkg::StDiv && div_need_q) begin
      half_q <= half_q << 1;
      if (trial >= {1'b0, den_q}) begin
        rem_q <= 16'(trial - {1'b0, den_q});
        quo_q <= {quo_q[15:0], 1'b1};
      end else begin
        rem_q <= trial[15:0];
        quo_q <= {quo_q[15:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      div_need_q <= 1'b0;
      we_q       <= 1'b0;
    end else if (state_q == adsr_pkg::StPrep) begin
      cnt_q      <= '0;
      div_need_q <= need;
      we_q       <= we;
    end else if (state_q == adsr_pkg::StDiv) begin
      cnt_q <= cnt_q + 4'd1;
    end
  end

  // result register
  adsr_pkg::out_t res_q;
  logic           res_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) res_valid_q <= 1'b0;
    else         res_valid_q <= (state_q == adsr_pkg::StFin);
  end

  always_ff @(posedge clk_i) begin
    if (state_q == adsr_pkg::StFin) begin
      res_q.multiplier   <= div_need_q ? quo_q : '0;
      res_q.phase        <= phase_q;
      res_q.release_done <= done_q;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== hdl/adsr_checker.sv =====
// ----------------------------------------------------------------------------
// adsr_checker
// Port-level checks on the ADSR envelope's command and result beats.
// ----------------------------------------------------------------------------
module adsr_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input logic           busy_o,
  input logic           res_valid_o,
  input adsr_pkg::out_t res_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("accepted beat did not raise busy");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o) else $error("result strobe longer than one cycle");

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy_o && $past(busy_o)) else $error("result while busy");

  a_mult_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> res_o.multiplier <= adsr_pkg::OneQ16) else $error("multiplier above 1.0");

  a_done_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.release_done |-> res_o.phase == adsr_pkg::PhRelease)
    else $error("release done outside release");

endmodule

bind polyphonic_adsr_envelope adsr_checker u_adsr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the polyphonic ADSR envelope: directed commands
// from a table, then random press/release/query/tick traffic; every result
// beat is compared against an envelope predictor held in the bench.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CycleLimit = 2000000;

  logic           clk_i;
  logic           rst_ni;
  logic           start_i;
  logic           busy_o;
  adsr_pkg::in_t  in_i;
  logic           res_valid_o;
  adsr_pkg::out_t res_o;
  logic           psel;
  logic           penable;
  logic           pwrite;
  logic [4:0]     paddr;
  logic [31:0]    pwdata;
  logic [31:0]    prdata;
  logic           pready;

  polyphonic_adsr_envelope u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .in_i       (in_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // envelope model state
  int unsigned env_attack, env_decay, env_sustain, env_release, env_period;
  int unsigned tick_cnt;
  bit          armed;
  int unsigned pos_q [adsr_pkg::NumNotes];
  adsr_pkg::phase_e mode_q [adsr_pkg::NumNotes];
  int unsigned rpos_q [adsr_pkg::NumNotes];

  adsr_pkg::out_t gain_fifo[$];
  int          n_err;
  int          n_cycles = 0;

  function automatic int unsigned rdiv(longint unsigned num, longint unsigned den);
    return int'((num + den / 2) / den);
  endfunction

  function automatic int unsigned sustain_phase_gain(int unsigned p);
    longint unsigned a, d, s, k;
    a = env_attack;
    d = env_decay;
    s = env_sustain;
    if (p <= a) return rdiv(longint'(p) * 65536, a);
    if (p <= a + d) begin
      k = p - a;
      return rdiv((255 * d - (255 - s) * k) * 65536, 255 * d);
    end
    return rdiv(s * 65536, 255);
  endfunction

  function automatic adsr_pkg::out_t envelope_step(adsr_pkg::in_t cmd);
    adsr_pkg::out_t   r;
    adsr_pkg::phase_e ph;
    int unsigned p;
    r = '0;
    if (cmd.action == adsr_pkg::ActTick) begin
      if (tick_cnt + 1 >= env_period) begin
        tick_cnt = 0;
        armed = 1;
      end else begin
        tick_cnt++;
        armed = 0;
      end
      return r;
    end
    if (cmd.action > adsr_pkg::ActQRel) return r;
    ph = mode_q[cmd.note];
    r.phase = ph;
    case (cmd.action)
      adsr_pkg::ActPress: begin
        pos_q[cmd.note] = 0;
        mode_q[cmd.note] = adsr_pkg::PhAttack;
      end
      adsr_pkg::ActRelease: begin
        if (ph != adsr_pkg::PhOff) begin
          mode_q[cmd.note] = adsr_pkg::PhRelease;
          rpos_q[cmd.note] = 0;
          pos_q[cmd.note] = 0;
        end
      end
      adsr_pkg::ActQHeld: begin
        if (ph == adsr_pkg::PhAttack || ph == adsr_pkg::PhDecay ||
            ph == adsr_pkg::PhSustain) begin
          p = pos_q[cmd.note];
          r.multiplier = adsr_pkg::MultW'(sustain_phase_gain(p));
          if (ph != adsr_pkg::PhSustain) begin
            p += armed;
            if (p > adsr_pkg::PosCap) p = adsr_pkg::PosCap;
            pos_q[cmd.note] = p;
            if (p > env_attack + env_decay) mode_q[cmd.note] = adsr_pkg::PhSustain;
            else if (p > env_attack) mode_q[cmd.note] = adsr_pkg::PhDecay;
          end
        end
      end
      default: begin
        if (ph == adsr_pkg::PhRelease) begin
          p = rpos_q[cmd.note];
          r.multiplier = (p >= env_release) ? '0 :
                         adsr_pkg::MultW'(rdiv(longint'(env_release - p) * 65536,
                                               env_release));
          p += armed;
          if (p >= env_release) begin
            p = 0;
            r.release_done = 1'b1;
            mode_q[cmd.note] = adsr_pkg::PhOff;
          end
          rpos_q[cmd.note] = p & 32'h1ff;
        end
      end
    endcase
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CycleLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    adsr_pkg::out_t exp_r;
    if (rst_ni && res_valid_o) begin
      if (gain_fifo.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result beat %p", res_o);
      end else begin
        exp_r = gain_fifo.pop_front();
        if (res_o.multiplier !== exp_r.multiplier || res_o.phase !== exp_r.phase ||
            res_o.release_done !== exp_r.release_done) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch: exp mult %0d ph %0d done %0d, got mult %0d ph %0d done %0d",
                     exp_r.multiplier, exp_r.phase, exp_r.release_done,
                     res_o.multiplier, res_o.phase, res_o.release_done);
        end
      end
    end
  end

  task automatic reg_write(adsr_pkg::reg_e idx, int unsigned val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(4 * idx);
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      adsr_pkg::RegAttack:  env_attack  = (val & 8'hff) == 0 ? 1 : val & 8'hff;
      adsr_pkg::RegDecay:   env_decay   = (val & 8'hff) == 0 ? 1 : val & 8'hff;
      adsr_pkg::RegSustain: env_sustain = val & 8'hff;
      adsr_pkg::RegRelease: env_release = (val & 8'hff) == 0 ? 1 : val & 8'hff;
      default:              env_period  = (val & 16'hffff) == 0 ? 1 : val & 16'hffff;
    endcase
  endtask

  task automatic idle_gap();
    int unsigned n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    repeat (n) @(negedge clk_i);
  endtask

  // drive one command; busy seen at a falling edge holds through the next rising edge
  task automatic issue_cmd(adsr_pkg::action_e act, logic [adsr_pkg::NoteW-1:0] nt);
    adsr_pkg::in_t cmd;
    cmd.action = act;
    cmd.note = nt;
    @(negedge clk_i);
    start_i <= 1'b1;
    in_i    <= cmd;
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
    gain_fifo.push_back(envelope_step(cmd));
    @(negedge clk_i);
    start_i <= 1'b0;
  endtask

  task automatic drain();
    while (gain_fifo.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  typedef struct {
    adsr_pkg::action_e act;
    int                nt;
    bit                has_exp;
    adsr_pkg::out_t    exp_r;
  } vec_t;

  vec_t dir_tab[$] = '{
    '{adsr_pkg::ActQHeld,   0,   1, '{0, 0, 0}},
    '{adsr_pkg::ActQRel,    127, 1, '{0, 0, 0}},
    '{adsr_pkg::ActRelease, 5,   1, '{0, 0, 0}},
    '{adsr_pkg::ActPress,   0,   1, '{0, 0, 0}},
    '{adsr_pkg::ActPress,   127, 1, '{0, 0, 0}},
    '{adsr_pkg::ActQHeld,   0,   1, '{0, 1, 0}},
    '{adsr_pkg::ActTick,    0,   1, '{0, 0, 0}},
    '{adsr_pkg::ActQHeld,   0,   0, '{0, 0, 0}},
    '{adsr_pkg::ActQHeld,   0,   0, '{0, 0, 0}},
    '{adsr_pkg::ActTick,    0,   0, '{0, 0, 0}},
    '{adsr_pkg::ActQHeld,   0,   0, '{0, 0, 0}},
    '{adsr_pkg::ActQHeld,   0,   0, '{0, 0, 0}},
    '{adsr_pkg::ActRelease, 0,   1, '{0, 3, 0}},
    '{adsr_pkg::ActQHeld,   0,   1, '{0, 4, 0}},
    '{adsr_pkg::ActQRel,    0,   1, '{65536, 4, 1}},
    '{adsr_pkg::ActQRel,    0,   1, '{0, 0, 0}},
    '{adsr_pkg::ActQHeld,   127, 0, '{0, 0, 0}},
    '{adsr_pkg::ActRelease, 127, 0, '{0, 0, 0}},
    '{adsr_pkg::ActPress,   127, 0, '{0, 0, 0}},
    '{adsr_pkg::ActQRel,    127, 0, '{0, 0, 0}}
  };

  initial begin
    logic [adsr_pkg::NoteW-1:0] nt;
    int unsigned k, len;
    adsr_pkg::out_t exp_r;
    n_err = 0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    in_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    env_attack = 1;
    env_decay = 1;
    env_sustain = 255;
    env_release = 1;
    env_period = 1;
    tick_cnt = 0;
    armed = 0;
    for (int i = 0; i < adsr_pkg::NumNotes; i++) begin
      pos_q[i] = 0;
      mode_q[i] = adsr_pkg::PhOff;
      rpos_q[i] = 0;
    end
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table at reset settings
    foreach (dir_tab[i]) begin
      exp_r = '0;
      issue_cmd(dir_tab[i].act, adsr_pkg::NoteW'(dir_tab[i].nt));
      if (dir_tab[i].has_exp) begin
        exp_r = gain_fifo[$];
        if (exp_r != dir_tab[i].exp_r) begin
          n_err++;
          if (n_err <= 10) $display("directed row %0d: table %p model %p",
                                    i, dir_tab[i].exp_r, exp_r);
        end
      end
      idle_gap();
    end
    drain();

    // random phases over several register settings, extremes first
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin reg_write(adsr_pkg::RegAttack, 255); reg_write(adsr_pkg::RegDecay, 255);
                 reg_write(adsr_pkg::RegSustain, 0); reg_write(adsr_pkg::RegRelease, 255);
                 reg_write(adsr_pkg::RegPeriod, 1); end
        1: begin reg_write(adsr_pkg::RegAttack, 1); reg_write(adsr_pkg::RegDecay, 1);
                 reg_write(adsr_pkg::RegSustain, 255); reg_write(adsr_pkg::RegRelease, 1);
                 reg_write(adsr_pkg::RegPeriod, 65535); end
        2: begin reg_write(adsr_pkg::RegAttack, 0); reg_write(adsr_pkg::RegDecay, 0);
                 reg_write(adsr_pkg::RegRelease, 0); reg_write(adsr_pkg::RegPeriod, 0); end
        default: begin
          reg_write(adsr_pkg::RegAttack, $urandom_range(1, 12));
          reg_write(adsr_pkg::RegDecay, $urandom_range(1, 12));
          reg_write(adsr_pkg::RegSustain, $urandom_range(0, 255));
          reg_write(adsr_pkg::RegRelease, $urandom_range(1, 12));
          reg_write(adsr_pkg::RegPeriod, $urandom_range(1, 3));
        end
      endcase
      k = 0;
      while (k < 300) begin
        // mostly a well-formed note life on a few notes, some noise
        nt = (ph == 1 || $urandom_range(0, 4) == 0) ? adsr_pkg::NoteW'($urandom) :
             adsr_pkg::NoteW'($urandom_range(0, 3));
        if ($urandom_range(0, 5) != 0) begin
          issue_cmd(adsr_pkg::ActPress, nt); k++;
          len = $urandom_range(2, (ph == 0) ? 60 : 25);
          repeat (len) begin
            issue_cmd($urandom_range(0, 1) ? adsr_pkg::ActTick : adsr_pkg::ActQHeld, nt);
            k++;
            idle_gap();
          end
          issue_cmd(adsr_pkg::ActRelease, nt); k++;
          len = $urandom_range(2, (ph == 0) ? 60 : 25);
          repeat (len) begin
            issue_cmd($urandom_range(0, 1) ? adsr_pkg::ActTick : adsr_pkg::ActQRel, nt);
            k++;
            idle_gap();
          end
        end else begin
          issue_cmd(adsr_pkg::action_e'($urandom_range(0, 4)), nt); k++;
          idle_gap();
        end
        if (k > 150 && k < 160) drain();
      end
      drain();
    end

    if (n_err == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/adsr_pkg.sv
hdl/polyphonic_adsr_envelope.sv
hdl/adsr_checker.sv
sim/tb_top.sv
